FILE: rtl/scmr_pkg.sv
`default_nettype none
package scmr_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ANGLE = 8'h41;
	localparam logic [7:0] CH_SPEED = 8'h53;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [7:0]        ANGLE_RESET = 8'd90;
	localparam logic signed [8:0] SPEED_RESET = 9'sd0;

	typedef enum logic [1:0] {
		DRIVE_OFF = 2'd0,
		DRIVE_FWD = 2'd1,
		DRIVE_REV = 2'd2
	} drive_mode_t;

	typedef struct packed {
		logic               angle_wr;
		logic               speed_wr;
		logic [7:0]         angle;
		logic signed [8:0]  speed;
	} target_upd_t;

endpackage
`default_nettype wire

FILE: rtl/scmr_parse.sv
`default_nettype none
module scmr_parse #(
	parameter int TEXT_SLOTS = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_en,
	input  wire logic [7:0]        byte_value,
	output scmr_pkg::target_upd_t  upd
);
	import scmr_pkg::*;

	localparam int CNT_W = $clog2(TEXT_SLOTS + 1);
	localparam logic [5:0] ACC_SAT = 6'd51;
	localparam logic [5:0] MAG_MAX = 6'd50;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t           phase_q;
	logic             neg_q;
	logic [5:0]       acc_q;
	logic [CNT_W-1:0] count_q;

	logic        is_digit;
	logic        is_sign;
	logic        is_space;
	logic        is_cmd_a;
	logic        is_cmd_s;
	logic        store_ok;
	logic [7:0]  digit_full;
	logic [9:0]  acc_mul;
	logic [5:0]  acc_sat;
	logic [5:0]  mag;
	logic [6:0]  tval;
	logic [9:0]  angle_prod;
	logic [17:0] angle_rec;
	logic [12:0] speed_prod;
	logic [25:0] speed_rec;
	logic [9:0]  speed_off;

	always_comb begin
		is_digit   = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
		is_sign    = (byte_value == CH_PLUS) || (byte_value == CH_MINUS);
		is_space   = (byte_value == CH_SPACE);
		is_cmd_a   = (byte_value == CH_ANGLE);
		is_cmd_s   = (byte_value == CH_SPEED);
		store_ok   = (is_digit || is_sign || is_space) && (count_q < CNT_W'(TEXT_SLOTS));
		digit_full = byte_value - CH_ZERO;
		acc_mul    = 10'(acc_q) * 10'd10 + 10'(digit_full[3:0]);
		acc_sat    = (acc_mul > 10'(ACC_SAT)) ? ACC_SAT : acc_mul[5:0];

		mag  = (acc_q > MAG_MAX) ? MAG_MAX : acc_q;
		tval = neg_q ? (7'd50 - 7'(mag)) : (7'd50 + 7'(mag));

		// Scale by 9/5 and 51/10 with reciprocal multiplies; both stay exact over 0..100.
		angle_prod = 10'(tval) * 10'd9;
		angle_rec  = 18'(angle_prod) * 18'd205;
		speed_prod = 13'(tval) * 13'd51;
		speed_rec  = 26'(speed_prod) * 26'd6554;
		speed_off  = speed_rec[25:16] - 10'd255;

		upd.angle_wr = byte_en && is_cmd_a;
		upd.speed_wr = byte_en && is_cmd_s;
		upd.angle    = angle_rec[17:10];
		upd.speed    = $signed(speed_off[8:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			count_q <= '0;
		end else if (byte_en) begin
			if (is_cmd_a || is_cmd_s) begin
				phase_q <= PH_LEAD;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				count_q <= '0;
			end else if (store_ok) begin
				count_q <= count_q + CNT_W'(1);
				unique case (phase_q)
					PH_LEAD: begin
						if (is_sign) begin
							neg_q   <= (byte_value == CH_MINUS);
							phase_q <= PH_DIGITS;
						end else if (is_digit) begin
							acc_q   <= acc_sat;
							phase_q <= PH_DIGITS;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							acc_q <= acc_sat;
						end else begin
							phase_q <= PH_DONE;
						end
					end
					PH_DONE: begin
						phase_q <= PH_DONE;
					end
					default: begin
						phase_q <= PH_DONE;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/scmr_ramp.sv
`default_nettype none
module scmr_ramp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tick_en,
	input  wire scmr_pkg::target_upd_t upd,
	output scmr_pkg::drive_mode_t      drive_mode,
	output logic [7:0]                 duty,
	output logic [7:0]                 actual_angle,
	output logic signed [8:0]          actual_speed
);
	import scmr_pkg::*;

	logic [7:0]        target_angle_q;
	logic signed [8:0] target_speed_q;
	logic [7:0]        angle_q;
	logic signed [8:0] speed_q;
	drive_mode_t       mode_q;
	logic [7:0]        duty_q;

	logic [7:0]        angle_nxt;
	logic signed [8:0] speed_nxt;
	logic signed [8:0] speed_neg;

	always_comb begin
		if (target_angle_q > angle_q) begin
			angle_nxt = angle_q + 8'd1;
		end else if (target_angle_q < angle_q) begin
			angle_nxt = angle_q - 8'd1;
		end else begin
			angle_nxt = angle_q;
		end
		if (target_speed_q > speed_q) begin
			speed_nxt = speed_q + 9'sd1;
		end else if (target_speed_q < speed_q) begin
			speed_nxt = speed_q - 9'sd1;
		end else begin
			speed_nxt = speed_q;
		end
		speed_neg = -speed_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_angle_q <= ANGLE_RESET;
			target_speed_q <= SPEED_RESET;
			angle_q        <= ANGLE_RESET;
			speed_q        <= SPEED_RESET;
			mode_q         <= DRIVE_OFF;
			duty_q         <= '0;
		end else begin
			if (upd.angle_wr) begin
				target_angle_q <= upd.angle;
			end
			if (upd.speed_wr) begin
				target_speed_q <= upd.speed;
			end
			if (tick_en) begin
				angle_q <= angle_nxt;
				speed_q <= speed_nxt;
				if (speed_nxt > 9'sd0) begin
					mode_q <= DRIVE_FWD;
					duty_q <= speed_nxt[7:0];
				end else if (speed_nxt < 9'sd0) begin
					mode_q <= DRIVE_REV;
					duty_q <= speed_neg[7:0];
				end
			end
		end
	end

	assign drive_mode   = mode_q;
	assign duty         = duty_q;
	assign actual_angle = angle_q;
	assign actual_speed = speed_q;

endmodule
`default_nettype wire

FILE: rtl/serial_command_motor_ramp_core.sv
// Accepted input goes to the input register, then its result to the state/result registers.
// One item per cycle unless the output stalls; s_axis_tready follows m_axis_tready combinationally.
// The input register and the state/result registers form the two stages.
// Reset (arst_n low, asynchronous) sets angles to 90, speeds, drive and duty to zero
// and empties the text store; the block accepts items in the first cycle after reset.
`default_nettype none
module serial_command_motor_ramp_core #(
	parameter int TEXT_SLOTS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
	input  wire logic        s_axis_tuser,   // cmd[0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // drive_mode[1:0], duty[9:2], actual_angle[17:10],
	                                         // actual_speed[26:18], zero[31:27]
);
	import scmr_pkg::*;

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic        m_valid_q;
	logic        out_free;
	logic        advance;

	target_upd_t       upd;
	drive_mode_t       drive_mode;
	logic [7:0]        duty;
	logic [7:0]        actual_angle;
	logic signed [8:0] actual_speed;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_free) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	scmr_parse #(
		.TEXT_SLOTS(TEXT_SLOTS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (advance && (cmd_s1 == CMD_BYTE)),
		.byte_value(byte_s1),
		.upd       (upd)
	);

	scmr_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_en     (advance && (cmd_s1 == CMD_TICK)),
		.upd         (upd),
		.drive_mode  (drive_mode),
		.duty        (duty),
		.actual_angle(actual_angle),
		.actual_speed(actual_speed)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, actual_speed, actual_angle, duty, drive_mode};

endmodule
`default_nettype wire

FILE: bench/serial_command_motor_ramp_checker.sv
`timescale 1ns / 1ps
module serial_command_motor_ramp_checker #(
	parameter int TEXT_SLOTS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
	input  wire logic        s_axis_tuser,   // cmd[0]
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,   // drive_mode[1:0], duty[9:2], actual_angle[17:10],
	                                         // actual_speed[26:18], zero[31:27]
	output int               fail_count,
	output int               pending_count,
	output int               result_count
);
	import scmr_pkg::*;

	localparam int CMD_LIMIT = 50;
	localparam int ANGLE_TOP = 180;
	localparam int SPEED_TOP = 255;

	typedef struct packed {
		drive_mode_t       mode;
		logic [7:0]        duty;
		logic [7:0]        angle;
		logic signed [8:0] speed;
	} motor_status_t;

	motor_status_t     status_queue [$];
	motor_status_t     expected;
	logic [7:0]        text_buf [TEXT_SLOTS];
	int                text_len;
	logic [7:0]        angle_goal;
	logic [7:0]        angle_now;
	logic signed [8:0] speed_goal;
	logic signed [8:0] speed_now;
	logic signed [8:0] speed_mag;
	drive_mode_t       mode_now;
	logic [7:0]        duty_now;
	int                scaled;
	int                mismatches = 0;

	function automatic int parse_text();
		int  pos;
		bit  negative;
		int  acc;
		pos = 0;
		negative = 1'b0;
		acc = 0;
		while (pos < text_len && text_buf[pos] == CH_SPACE)
			pos++;
		if (pos < text_len && (text_buf[pos] == CH_PLUS || text_buf[pos] == CH_MINUS)) begin
			negative = (text_buf[pos] == CH_MINUS);
			pos++;
		end
		while (pos < text_len && text_buf[pos] >= CH_ZERO && text_buf[pos] <= CH_NINE) begin
			acc = acc * 10 + (int'(text_buf[pos]) - int'(CH_ZERO));
			pos++;
		end
		return negative ? -acc : acc;
	endfunction

	function automatic int scale_cmd(input int value, input int out_lo, input int out_hi);
		int clamped;
		clamped = (value < -CMD_LIMIT) ? -CMD_LIMIT : ((value > CMD_LIMIT) ? CMD_LIMIT : value);
		return (clamped + CMD_LIMIT) * (out_hi - out_lo) / (2 * CMD_LIMIT) + out_lo;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_queue.delete();
			text_len = 0;
			angle_goal = ANGLE_RESET;
			angle_now = ANGLE_RESET;
			speed_goal = SPEED_RESET;
			speed_now = SPEED_RESET;
			mode_now = DRIVE_OFF;
			duty_now = 8'd0;
			fail_count <= mismatches;
			pending_count <= 0;
			result_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_count <= result_count + 1;
				if (status_queue.size() == 0) begin
					$display("%0t ns: result transaction %h arrived with nothing expected",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					expected = status_queue.pop_front();
					check_field("drive_mode", expected.mode, m_axis_tdata[1:0]);
					check_field("duty", expected.duty, m_axis_tdata[9:2]);
					check_field("actual_angle", expected.angle, m_axis_tdata[17:10]);
					check_field("actual_speed", $signed(expected.speed),
						$signed(m_axis_tdata[26:18]));
					check_field("padding", 0, m_axis_tdata[31:27]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == CMD_TICK) begin
					if (angle_goal > angle_now)
						angle_now = angle_now + 8'd1;
					else if (angle_goal < angle_now)
						angle_now = angle_now - 8'd1;
					if (speed_goal > speed_now)
						speed_now = speed_now + 9'sd1;
					else if (speed_goal < speed_now)
						speed_now = speed_now - 9'sd1;
					if (speed_now > 9'sd0) begin
						mode_now = DRIVE_FWD;
						duty_now = speed_now[7:0];
					end else if (speed_now < 9'sd0) begin
						mode_now = DRIVE_REV;
						speed_mag = -speed_now;
						duty_now = speed_mag[7:0];
					end
				end else if (s_axis_tdata == CH_ANGLE) begin
					scaled = scale_cmd(parse_text(), 0, ANGLE_TOP);
					angle_goal = scaled[7:0];
					text_len = 0;
				end else if (s_axis_tdata == CH_SPEED) begin
					scaled = scale_cmd(parse_text(), -SPEED_TOP, SPEED_TOP);
					speed_goal = scaled[8:0];
					text_len = 0;
				end else if ((s_axis_tdata >= CH_ZERO && s_axis_tdata <= CH_NINE) ||
					s_axis_tdata == CH_PLUS || s_axis_tdata == CH_MINUS ||
					s_axis_tdata == CH_SPACE) begin
					if (text_len < TEXT_SLOTS) begin
						text_buf[text_len] = s_axis_tdata;
						text_len++;
					end
				end
				status_queue.push_back(motor_status_t'{mode_now, duty_now, angle_now, speed_now});
			end
			fail_count <= mismatches;
			pending_count <= status_queue.size();
		end
	end

endmodule

FILE: bench/tb_serial_command_motor_ramp_core.sv
`timescale 1ns / 1ps
module tb_serial_command_motor_ramp_core;
	import scmr_pkg::*;

	localparam int ITEM_TARGET = 1950;
	localparam int IDLE_LIMIT  = 2000;
	localparam int LONG_HOLD   = 400;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire logic   s_axis_tready;
	logic [7:0]  s_axis_tdata;   // byte_value[7:0]
	logic        s_axis_tuser;   // cmd[0]
	wire logic   m_axis_tvalid;
	logic        m_axis_tready;
	wire logic [31:0] m_axis_tdata;   // drive_mode[1:0], duty[9:2], actual_angle[17:10],
	                                  // actual_speed[26:18], zero[31:27]

	int fail_count;
	int pending_count;
	int result_count;
	int parsed_items = 0;
	int tick_items = 0;
	int byte_items = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int rx_cycle = 0;
	int rx_phase_left = 0;
	int rx_phase_kind = 0;
	int choice;
	int run_len;

	serial_command_motor_ramp_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	serial_command_motor_ramp_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic send_item(input logic cmd_bit, input logic [7:0] value);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd_bit;
		s_axis_tdata <= value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (cmd_bit == CMD_TICK)
			tick_items++;
		else
			byte_items++;
		if (cmd_bit == CMD_TICK || value == CH_ANGLE || value == CH_SPEED ||
			(value >= CH_ZERO && value <= CH_NINE) || value == CH_PLUS ||
			value == CH_MINUS || value == CH_SPACE)
			parsed_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			s_axis_tuser <= 1'($urandom);
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 15);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = CMD_BYTE;
		s_axis_tdata = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: range ends, store overflow, ignored bytes, spaces, double sign,
		// empty store and a speed that ramps back to zero.
		send_item(CMD_BYTE, CH_MINUS);
		send_item(CMD_BYTE, 8'(CH_ZERO + 5));
		send_item(CMD_BYTE, CH_ZERO);
		send_item(CMD_BYTE, CH_SPEED);
		send_item(CMD_TICK, 8'hFF);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_BYTE, CH_PLUS);
		send_item(CMD_BYTE, CH_NINE);
		send_item(CMD_BYTE, CH_NINE);
		send_item(CMD_BYTE, CH_NINE);
		send_item(CMD_BYTE, CH_ANGLE);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, 8'h7A);
		send_item(CMD_BYTE, CH_SPACE);
		send_item(CMD_BYTE, CH_SPACE);
		send_item(CMD_BYTE, 8'(CH_ZERO + 7));
		send_item(CMD_BYTE, CH_ANGLE);
		send_item(CMD_BYTE, CH_SPEED);
		send_item(CMD_BYTE, CH_PLUS);
		send_item(CMD_BYTE, CH_MINUS);
		send_item(CMD_BYTE, 8'(CH_ZERO + 5));
		send_item(CMD_BYTE, CH_SPEED);
		send_item(CMD_TICK, 8'h55);
		send_item(CMD_TICK, 8'hAA);

		while (parsed_items < ITEM_TARGET) begin
			choice = $urandom_range(0, 9);
			if (choice < 7) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2)) send_item(CMD_BYTE, CH_SPACE);
				case ($urandom_range(0, 3))
					0: send_item(CMD_BYTE, CH_PLUS);
					1: send_item(CMD_BYTE, CH_MINUS);
					default: ;
				endcase
				repeat ($urandom_range(0, 4))
					send_item(CMD_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));
				send_item(CMD_BYTE, $urandom_range(0, 1) ? CH_ANGLE : CH_SPEED);
				run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
					: $urandom_range(1, 20);
				repeat (run_len) send_item(CMD_TICK, 8'($urandom));
			end else if (choice < 9) begin
				repeat ($urandom_range(1, 4)) send_item(CMD_BYTE, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: send_item(CMD_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));
						1: send_item(CMD_BYTE, CH_PLUS);
						2: send_item(CMD_BYTE, CH_MINUS);
						default: send_item(CMD_BYTE, CH_SPACE);
					endcase
				end
				if ($urandom_range(0, 1))
					send_item(CMD_BYTE, $urandom_range(0, 1) ? CH_ANGLE : CH_SPEED);
			end
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d command bytes and %0d ramp ticks; %0d result transactions checked.",
			byte_items, tick_items, result_count);
		$display("Stimulus covered clamped and in-range targets, store overflow and long stalls.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 2000 == 1000) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (rx_phase_left == 0) begin
					rx_phase_kind = $urandom_range(0, 3);
					rx_phase_left = $urandom_range(20, 200);
				end
				rx_phase_left--;
				case (rx_phase_kind)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= rx_cycle[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

FILE: files.f
rtl/scmr_pkg.sv
rtl/scmr_parse.sv
rtl/scmr_ramp.sv
rtl/serial_command_motor_ramp_core.sv
bench/serial_command_motor_ramp_checker.sv
bench/tb_serial_command_motor_ramp_core.sv
